### hdl/svpr_pkg.sv
package svpr_pkg;

  localparam int SERVO_CHANNELS_DEF = 4;
  localparam int WIDTH_BITS = 13;
  localparam int LIMIT_BITS = 16;
  localparam int DIV_BITS = 16;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS = 64;
  localparam int IN_DATA_BITS = 8;
  localparam int OUT_DATA_BITS = 64;
  localparam int MASK_LSB = 4 * WIDTH_BITS;
  localparam int RAMP_BIT = MASK_LSB + 4;

  localparam logic [WIDTH_BITS-1:0] PWM_MIN_COUNT = 13'd1400;
  localparam logic [WIDTH_BITS-1:0] PWM_MAX_COUNT = 13'd5600;
  localparam logic [WIDTH_BITS-1:0] PWM_CENTRE_COUNT = 13'd3000;

  localparam logic [WIDTH_BITS-1:0] STEP_SIZE_RESET = 13'd20;
  localparam logic [DIV_BITS-1:0] SPEED_DIVIDER_RESET = 16'd0;
  localparam logic [63:0] MIN_POSITIONS_RESET = 64'd394070980440884600;
  localparam logic [63:0] MAX_POSITIONS_RESET = 64'd1576283921763538400;
  localparam logic [3:0] SWITCH_POLARITY_RESET = 4'd0;

  typedef enum logic [1:0] {
    OP_SET_POSITION = 2'd0,
    OP_FRAME_TICK   = 2'd1,
    OP_SNAP         = 2'd2,
    OP_UNUSED       = 2'd3
  } op_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_STEP_SIZE       = 3'd0,
    CFG_SPEED_DIVIDER   = 3'd1,
    CFG_MIN_POSITIONS   = 3'd2,
    CFG_MAX_POSITIONS   = 3'd3,
    CFG_SWITCH_POLARITY = 3'd4
  } cfg_index_t;

  typedef struct packed {
    logic                busy;
    logic                done;
    logic [DIV_BITS-1:0] remainder;
  } mod_status_t;

  function automatic logic [WIDTH_BITS-1:0] clamp_width(input logic [LIMIT_BITS-1:0] v);
    logic [WIDTH_BITS-1:0] res;
    if (v < LIMIT_BITS'(PWM_MIN_COUNT)) begin
      res = PWM_MIN_COUNT;
    end else if (v > LIMIT_BITS'(PWM_MAX_COUNT)) begin
      res = PWM_MAX_COUNT;
    end else begin
      res = v[WIDTH_BITS-1:0];
    end
    return res;
  endfunction

endpackage

### hdl/svpr_mod_unit.sv
module svpr_mod_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [svpr_pkg::DIV_BITS-1:0]   dividend,
  input  logic [svpr_pkg::DIV_BITS-1:0]   divisor,
  output svpr_pkg::mod_status_t           status
);

  localparam int CNT_BITS = $clog2(svpr_pkg::DIV_BITS + 1);

  logic                          busy_r;
  logic                          done_r;
  logic [CNT_BITS-1:0]           cnt_r;
  logic [svpr_pkg::DIV_BITS-1:0] rem_r;
  logic [svpr_pkg::DIV_BITS-1:0] dvd_r;
  logic [svpr_pkg::DIV_BITS-1:0] dsr_r;
  logic [svpr_pkg::DIV_BITS:0]   trial;
  logic [svpr_pkg::DIV_BITS-1:0] rem_nxt;

  always_comb begin
    trial = {rem_r, dvd_r[svpr_pkg::DIV_BITS-1]};
    if (trial >= {1'b0, dsr_r}) begin
      rem_nxt = svpr_pkg::DIV_BITS'(trial - {1'b0, dsr_r});
    end else begin
      rem_nxt = trial[svpr_pkg::DIV_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNT_BITS'(svpr_pkg::DIV_BITS);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNT_BITS'(1);
      if (cnt_r == CNT_BITS'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvd_r <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dvd_r <= {dvd_r[svpr_pkg::DIV_BITS-2:0], 1'b0};
    end
  end

  assign status.busy      = busy_r | done_r;
  assign status.done      = done_r;
  assign status.remainder = rem_r;

endmodule

### hdl/servo_position_ramp.sv
// Results are registered in the output register, or in the skid entry while it is stalled.
// Throughput: one item per cycle while in_tready is high; a two-entry output stage takes an
// item while a result waits. A write of speed_divider starts a bit-serial modulo of the
// tick counter (one bit a cycle) and holds in_tready low while the divider phase is rebuilt.
// Reset (rst_n, synchronous): registers to their defaults, all widths and targets to 3000,
// tick counter zero, output stage empty.
module servo_position_ramp #(
  parameter int SERVO_CHANNELS = svpr_pkg::SERVO_CHANNELS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // [1:0] servo_index, [2] position_bit
  input  logic [svpr_pkg::IN_DATA_BITS-1:0]     in_tdata,
  // [1:0] op
  input  logic [1:0]                            in_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // [12:0] width_servo0, [25:13] width_servo1, [38:26] width_servo2,
  // [51:39] width_servo3, [55:52] at_target_mask, [56] ramp_applied
  output logic [svpr_pkg::OUT_DATA_BITS-1:0]    out_tdata,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [svpr_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [svpr_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  localparam int WB = svpr_pkg::WIDTH_BITS;
  localparam int DB = svpr_pkg::DIV_BITS;

  logic [WB-1:0] step_size_r;
  logic [DB-1:0] speed_divider_r;
  logic [63:0]   min_positions_r;
  logic [63:0]   max_positions_r;
  logic [3:0]    switch_polarity_r;

  logic [WB-1:0] target_r [SERVO_CHANNELS];
  logic [WB-1:0] target_nxt [SERVO_CHANNELS];
  logic [WB-1:0] current_r [SERVO_CHANNELS];
  logic [WB-1:0] current_nxt [SERVO_CHANNELS];
  logic [DB-1:0] tick_r;
  logic [DB-1:0] tick_nxt;
  logic [DB-1:0] phase_r;
  logic [DB-1:0] phase_nxt;

  logic                             out_valid_r;
  logic [svpr_pkg::OUT_DATA_BITS-1:0] out_data_r;
  logic                             skid_valid_r;
  logic [svpr_pkg::OUT_DATA_BITS-1:0] skid_data_r;
  logic [svpr_pkg::OUT_DATA_BITS-1:0] res_data;
  logic [3:0]                       mask;
  logic                             ramped;

  logic                  in_fire;
  logic                  out_fire;
  logic                  cfg_fire;
  logic                  mod_start;
  svpr_pkg::mod_status_t mod_status;
  svpr_pkg::op_t         op;
  logic [1:0]            servo_index;
  logic                  position_bit;
  logic [DB:0]           phase_inc;

  function automatic logic [WB-1:0] ramp_one(input logic [WB-1:0] w, input logic [WB-1:0] t,
                                             input logic [WB-1:0] step);
    logic [WB-1:0] res;
    if (t < w) begin
      res = (step < (w - t)) ? (w - step) : t;
    end else if (t > w) begin
      res = (step < (t - w)) ? (w + step) : t;
    end else begin
      res = w;
    end
    return res;
  endfunction

  assign op           = svpr_pkg::op_t'(in_tuser);
  assign servo_index  = in_tdata[1:0];
  assign position_bit = in_tdata[2];

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid & cfg_ready;
  assign mod_start = cfg_fire && (cfg_index == svpr_pkg::CFG_SPEED_DIVIDER);

  assign in_tready = !skid_valid_r && !mod_status.busy;
  assign in_fire   = in_tvalid & in_tready;
  assign out_fire  = out_valid_r & out_tready;

  svpr_mod_unit u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (tick_r),
    .divisor  (cfg_data[DB-1:0]),
    .status   (mod_status)
  );

  assign phase_inc = {1'b0, phase_r} + (DB+1)'(1);

  always_comb begin
    logic [svpr_pkg::LIMIT_BITS-1:0] lim;
    logic go;
    lim    = '0;
    go     = 1'b0;
    ramped = 1'b0;
    tick_nxt  = tick_r;
    phase_nxt = phase_r;
    for (int n = 0; n < SERVO_CHANNELS; n++) begin
      target_nxt[n]  = target_r[n];
      current_nxt[n] = current_r[n];
    end
    unique case (op)
      svpr_pkg::OP_SET_POSITION: begin
        for (int n = 0; n < SERVO_CHANNELS; n++) begin
          if (servo_index == 2'(n)) begin
            lim = (position_bit == switch_polarity_r[n]) ? min_positions_r[16*n +: 16]
                                                          : max_positions_r[16*n +: 16];
            target_nxt[n] = svpr_pkg::clamp_width(lim);
          end
        end
      end
      svpr_pkg::OP_FRAME_TICK: begin
        if (speed_divider_r == '0) begin
          go = 1'b1;
        end else begin
          go       = (phase_r == '0);
          tick_nxt = tick_r + DB'(1);
          if (tick_r == '1 || phase_inc == {1'b0, speed_divider_r}) begin
            phase_nxt = '0;
          end else begin
            phase_nxt = phase_inc[DB-1:0];
          end
        end
        if (go) begin
          ramped = 1'b1;
          for (int n = 0; n < SERVO_CHANNELS; n++) begin
            current_nxt[n] = ramp_one(current_r[n], target_r[n], step_size_r);
          end
        end
      end
      svpr_pkg::OP_SNAP: begin
        for (int n = 0; n < SERVO_CHANNELS; n++) begin
          current_nxt[n] = target_r[n];
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    mask = '0;
    for (int n = 0; n < SERVO_CHANNELS; n++) begin
      mask[n] = (current_nxt[n] == target_nxt[n]);
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_pack
    if (g < SERVO_CHANNELS) begin : g_on
      assign res_data[WB*g +: WB] = current_nxt[g];
    end else begin : g_off
      assign res_data[WB*g +: WB] = '0;
    end
  end
  assign res_data[svpr_pkg::MASK_LSB +: 4] = mask;
  assign res_data[svpr_pkg::RAMP_BIT]      = ramped;
  assign res_data[svpr_pkg::OUT_DATA_BITS-1:svpr_pkg::RAMP_BIT+1] = '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_size_r       <= svpr_pkg::STEP_SIZE_RESET;
      speed_divider_r   <= svpr_pkg::SPEED_DIVIDER_RESET;
      min_positions_r   <= svpr_pkg::MIN_POSITIONS_RESET;
      max_positions_r   <= svpr_pkg::MAX_POSITIONS_RESET;
      switch_polarity_r <= svpr_pkg::SWITCH_POLARITY_RESET;
    end else if (cfg_fire) begin
      unique case (cfg_index)
        svpr_pkg::CFG_STEP_SIZE:       step_size_r       <= cfg_data[WB-1:0];
        svpr_pkg::CFG_SPEED_DIVIDER:   speed_divider_r   <= cfg_data[DB-1:0];
        svpr_pkg::CFG_MIN_POSITIONS:   min_positions_r   <= cfg_data;
        svpr_pkg::CFG_MAX_POSITIONS:   max_positions_r   <= cfg_data;
        svpr_pkg::CFG_SWITCH_POLARITY: switch_polarity_r <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int n = 0; n < SERVO_CHANNELS; n++) begin
        target_r[n]  <= svpr_pkg::PWM_CENTRE_COUNT;
        current_r[n] <= svpr_pkg::PWM_CENTRE_COUNT;
      end
      tick_r  <= '0;
      phase_r <= '0;
    end else if (in_fire) begin
      for (int n = 0; n < SERVO_CHANNELS; n++) begin
        target_r[n]  <= target_nxt[n];
        current_r[n] <= current_nxt[n];
      end
      tick_r  <= tick_nxt;
      phase_r <= phase_nxt;
    end else if (mod_status.done) begin
      phase_r <= mod_status.remainder;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_fire || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_fire || !out_valid_r) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
      end else if (in_fire) begin
        out_data_r <= res_data;
      end
    end else if (in_fire) begin
      skid_data_r <= res_data;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

### dv/tb_servo_position_ramp.sv
module tb_servo_position_ramp;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CHANNELS = svpr_pkg::SERVO_CHANNELS_DEF;
  localparam int WBITS = svpr_pkg::WIDTH_BITS;
  localparam int MAX_REPORTS = 10;
  localparam int SETTLE_CYCLES = 20;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS = 250;

  typedef struct packed {
    logic [3:0][WBITS-1:0] width;
    logic [3:0]            at_target;
    logic                  ramped;
  } servo_frame_t;

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                in_tvalid = 1'b0;
  logic                                in_tready;
  logic [svpr_pkg::IN_DATA_BITS-1:0]   in_tdata = '0;
  logic [1:0]                          in_tuser = '0;
  logic                                out_tvalid;
  logic                                out_tready = 1'b0;
  logic [svpr_pkg::OUT_DATA_BITS-1:0]  out_tdata;
  logic                                cfg_valid = 1'b0;
  logic                                cfg_ready;
  logic [svpr_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [svpr_pkg::CFG_DATA_BITS-1:0]  cfg_data = '0;

  logic [WBITS-1:0]              step_q = svpr_pkg::STEP_SIZE_RESET;
  logic [svpr_pkg::DIV_BITS-1:0] div_q = svpr_pkg::SPEED_DIVIDER_RESET;
  logic [63:0]                   min_q = svpr_pkg::MIN_POSITIONS_RESET;
  logic [63:0]                   max_q = svpr_pkg::MAX_POSITIONS_RESET;
  logic [3:0]                    pol_q = svpr_pkg::SWITCH_POLARITY_RESET;
  logic [WBITS-1:0]              tgt_q [4] = '{default: svpr_pkg::PWM_CENTRE_COUNT};
  logic [WBITS-1:0]              cur_q [4] = '{default: svpr_pkg::PWM_CENTRE_COUNT};
  logic [svpr_pkg::DIV_BITS-1:0] ticks_q = '0;

  servo_frame_t pending_frames[$];
  bit fast_phase = 1'b0;
  int rx_wait = 0;
  int mismatches = 0;
  int items_sent = 0;
  int frames_checked = 0;
  int ramps_expected = 0;
  int reg_writes = 0;

  servo_position_ramp uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [WBITS-1:0] limit_to_pwm(logic [svpr_pkg::LIMIT_BITS-1:0] v);
    if (v < svpr_pkg::PWM_MIN_COUNT) return svpr_pkg::PWM_MIN_COUNT;
    if (v > svpr_pkg::PWM_MAX_COUNT) return svpr_pkg::PWM_MAX_COUNT;
    return v[WBITS-1:0];
  endfunction

  function automatic servo_frame_t advance_servos(svpr_pkg::op_t op, logic [1:0] idx, logic pos);
    servo_frame_t f;
    logic go;
    logic [svpr_pkg::LIMIT_BITS-1:0] lim;
    logic [WBITS-1:0] gap_cnt;
    f = '0;
    case (op)
      svpr_pkg::OP_SET_POSITION: begin
        if (int'(idx) < CHANNELS) begin
          lim = (pos == pol_q[idx]) ? min_q[16*int'(idx) +: 16] : max_q[16*int'(idx) +: 16];
          tgt_q[idx] = limit_to_pwm(lim);
        end
      end
      svpr_pkg::OP_FRAME_TICK: begin
        if (div_q == '0) begin
          go = 1'b1;
        end else begin
          go = (ticks_q % div_q) == '0;
          ticks_q = ticks_q + 1'b1;
        end
        if (go) begin
          for (int n = 0; n < CHANNELS; n++) begin
            if (tgt_q[n] < cur_q[n]) begin
              gap_cnt = cur_q[n] - tgt_q[n];
              cur_q[n] = cur_q[n] - ((step_q < gap_cnt) ? step_q : gap_cnt);
            end else if (tgt_q[n] > cur_q[n]) begin
              gap_cnt = tgt_q[n] - cur_q[n];
              cur_q[n] = cur_q[n] + ((step_q < gap_cnt) ? step_q : gap_cnt);
            end
          end
          f.ramped = 1'b1;
        end
      end
      svpr_pkg::OP_SNAP: begin
        for (int n = 0; n < CHANNELS; n++) cur_q[n] = tgt_q[n];
      end
      default: ;
    endcase
    for (int n = 0; n < CHANNELS; n++) begin
      f.width[n] = cur_q[n];
      f.at_target[n] = cur_q[n] == tgt_q[n];
    end
    return f;
  endfunction

  function automatic logic [63:0] random_limits();
    logic [63:0] v;
    for (int n = 0; n < 4; n++)
      v[16*n +: 16] = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                 : 16'($urandom_range(1400, 5600));
    return v;
  endfunction

  task automatic check_frame(logic [svpr_pkg::OUT_DATA_BITS-1:0] d);
    servo_frame_t want;
    servo_frame_t got;
    for (int n = 0; n < 4; n++) got.width[n] = d[n*WBITS +: WBITS];
    got.at_target = d[svpr_pkg::MASK_LSB +: 4];
    got.ramped = d[svpr_pkg::RAMP_BIT];
    if (pending_frames.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("unexpected result: tdata=%h", d);
      return;
    end
    want = pending_frames.pop_front();
    frames_checked++;
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display({"mismatch: expected w=%0d/%0d/%0d/%0d mask=%b ramp=%b,",
                  " got w=%0d/%0d/%0d/%0d mask=%b ramp=%b"},
                 want.width[0], want.width[1], want.width[2], want.width[3],
                 want.at_target, want.ramped,
                 got.width[0], got.width[1], got.width[2], got.width[3],
                 got.at_target, got.ramped);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        check_frame(out_tdata);
        rx_wait = fast_phase ? 0 : $urandom_range(0, 10);
      end
      if (rx_wait > 0) begin
        out_tready <= 1'b0;
        rx_wait--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_command(svpr_pkg::op_t op, logic [1:0] idx, logic pos);
    int gap;
    servo_frame_t f;
    gap = fast_phase ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= svpr_pkg::IN_DATA_BITS'({pos, idx});
    in_tuser <= op;
    do @(posedge clk); while (!in_tready);
    f = advance_servos(op, idx, pos);
    pending_frames.push_back(f);
    items_sent++;
    if (f.ramped) ramps_expected++;
  endtask

  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_frames.size() != 0);
  endtask

  task automatic apply_settings(logic [WBITS-1:0] step, logic [svpr_pkg::DIV_BITS-1:0] div,
                                logic [63:0] mins, logic [63:0] maxs, logic [3:0] pol);
    svpr_pkg::cfg_index_t regs [5];
    logic [63:0] vals [5];
    regs = '{svpr_pkg::CFG_STEP_SIZE, svpr_pkg::CFG_SPEED_DIVIDER, svpr_pkg::CFG_MIN_POSITIONS,
             svpr_pkg::CFG_MAX_POSITIONS, svpr_pkg::CFG_SWITCH_POLARITY};
    vals = '{64'(step), 64'(div), mins, maxs, 64'(pol)};
    wait_for_results();
    for (int i = 0; i < 5; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      reg_writes++;
      case (regs[i])
        svpr_pkg::CFG_STEP_SIZE:       step_q = vals[i][WBITS-1:0];
        svpr_pkg::CFG_SPEED_DIVIDER:   div_q = vals[i][svpr_pkg::DIV_BITS-1:0];
        svpr_pkg::CFG_MIN_POSITIONS:   min_q = vals[i];
        svpr_pkg::CFG_MAX_POSITIONS:   max_q = vals[i];
        svpr_pkg::CFG_SWITCH_POLARITY: pol_q = vals[i][3:0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_state();
    send_command(svpr_pkg::OP_UNUSED, 2'd3, 1'b1);
    send_command(svpr_pkg::OP_SNAP, 2'd0, 1'b0);
  endtask

  task automatic test_position_commands();
    send_command(svpr_pkg::OP_SET_POSITION, 2'd0, 1'b0);
    send_command(svpr_pkg::OP_SET_POSITION, 2'd1, 1'b1);
    send_command(svpr_pkg::OP_SET_POSITION, 2'd2, 1'b0);
    send_command(svpr_pkg::OP_SET_POSITION, 2'd3, 1'b1);
    send_command(svpr_pkg::OP_FRAME_TICK, 2'd2, 1'b1);
    send_command(svpr_pkg::OP_FRAME_TICK, 2'd1, 1'b0);
  endtask

  task automatic test_clamping_and_step_extremes();
    apply_settings(13'd4200, '0, 64'h0, {64{1'b1}}, 4'hF);
    send_command(svpr_pkg::OP_SET_POSITION, 2'd0, 1'b1);
    send_command(svpr_pkg::OP_SET_POSITION, 2'd3, 1'b0);
    send_command(svpr_pkg::OP_SET_POSITION, 2'd1, 1'b0);
    send_command(svpr_pkg::OP_FRAME_TICK, 2'd0, 1'b0);
    send_command(svpr_pkg::OP_UNUSED, 2'd0, 1'b0);
    apply_settings('0, '0, {16'd5000, 16'd2000, 16'd1401, 16'd5599},
                   {16'd1399, 16'd5601, 16'd3000, 16'd1400}, 4'h5);
    send_command(svpr_pkg::OP_SET_POSITION, 2'd2, 1'b1);
    send_command(svpr_pkg::OP_FRAME_TICK, 2'd3, 1'b1);
    send_command(svpr_pkg::OP_SNAP, 2'd1, 1'b1);
  endtask

  task automatic test_tick_divider();
    apply_settings(13'd20, 16'hFFFF, svpr_pkg::MIN_POSITIONS_RESET,
                   svpr_pkg::MAX_POSITIONS_RESET, 4'h0);
    send_command(svpr_pkg::OP_SET_POSITION, 2'd0, 1'b1);
    repeat (3) send_command(svpr_pkg::OP_FRAME_TICK, 2'd0, 1'b0);
    apply_settings(13'd20, 16'd1, svpr_pkg::MIN_POSITIONS_RESET,
                   svpr_pkg::MAX_POSITIONS_RESET, 4'h0);
    send_command(svpr_pkg::OP_FRAME_TICK, 2'd1, 1'b1);
    apply_settings(13'd20, 16'd3, svpr_pkg::MIN_POSITIONS_RESET,
                   svpr_pkg::MAX_POSITIONS_RESET, 4'h0);
    repeat (3) send_command(svpr_pkg::OP_FRAME_TICK, 2'd3, 1'b0);
  endtask

  task automatic test_random_traffic();
    int r;
    logic [WBITS-1:0] step;
    logic [svpr_pkg::DIV_BITS-1:0] div;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      fast_phase = (p == 2) || (p == 4);
      r = $urandom_range(0, 9);
      step = r == 0 ? 13'd4200 : r < 3 ? 13'($urandom_range(0, 4200))
           : r < 7 ? 13'($urandom_range(1, 40)) : 13'($urandom_range(100, 800));
      r = $urandom_range(0, 9);
      div = r < 5 ? 16'($urandom_range(0, 3)) : r < 8 ? 16'($urandom_range(4, 12))
          : r == 8 ? 16'hFFFF : 16'($urandom);
      apply_settings(step, div, random_limits(), random_limits(), 4'($urandom_range(0, 15)));
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // hold off until the output side has caught up
        if (p == 3 && k == PHASE_ITEMS / 2) wait_for_results();
        r = $urandom_range(0, 99);
        send_command(r < 35 ? svpr_pkg::OP_SET_POSITION : r < 85 ? svpr_pkg::OP_FRAME_TICK
                     : r < 93 ? svpr_pkg::OP_SNAP : svpr_pkg::OP_UNUSED,
                     2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      end
    end
    fast_phase = 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_position_commands();
    test_clamping_and_step_extremes();
    test_tick_divider();
    test_random_traffic();
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Covered %0d command, tick and snap transfers; %0d results checked, %0d ramping.",
             items_sent, frames_checked, ramps_expected);
    $display("Register transfers: %0d, spanning step, divider, limit and polarity extremes.",
             reg_writes);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

### files.f
hdl/svpr_pkg.sv
hdl/svpr_mod_unit.sv
hdl/servo_position_ramp.sv
dv/tb_servo_position_ramp.sv
